FILE: rtl/core/phr_pkg.sv
// package for the position history ring: sizes, ring index helpers,
// operation codes and the entry write request shared by the top level and the store
// no dependencies
`timescale 1ns / 1ps

package phr_pkg;

  localparam int DEPTH   = 16;
  localparam int COORD_W = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_BACK = 2'd1,
    FUNC_FWD  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef struct packed {
    logic   we;
    idx_t   addr;
    coord_t x;
    coord_t y;
  } wr_req_t;

  function automatic idx_t ring_inc(input idx_t i);
    return (i == LAST_IDX) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t ring_dec(input idx_t i);
    return (i == '0) ? LAST_IDX : idx_t'(i - 1'b1);
  endfunction

endpackage

FILE: rtl/core/phr_store.sv
// entry store of the position history ring: one write port, one read port
// depends on phr_pkg
`timescale 1ns / 1ps

module phr_store (
  input  logic             clk,
  input  phr_pkg::wr_req_t wr,
  input  phr_pkg::idx_t    rd_addr,
  output phr_pkg::coord_t  rd_x,
  output phr_pkg::coord_t  rd_y
);
  import phr_pkg::*;

  coord_t entry_x_r [DEPTH];
  coord_t entry_y_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      entry_x_r[wr.addr] <= wr.x;
      entry_y_r[wr.addr] <= wr.y;
    end
  end

  assign rd_x = entry_x_r[rd_addr];
  assign rd_y = entry_y_r[rd_addr];

endmodule

FILE: rtl/core/position_history_ring_unit.sv
// top level of the position history ring: pointer control and result register
// depends on phr_pkg and phr_store
`timescale 1ns / 1ps

// Back/forward history of (x,y) positions in a ring of DEPTH entries. An item
// (add, step back, step forward, or code 3 for a plain query) is taken at a rising
// edge where start is high and busy is low; busy is high during reset and until
// the first edge after it, so an item can enter every cycle. Its result shows
// on the out_ ports for one cycle, marked by out_valid, in the cycle after the
// item was taken. The rate is one item per cycle: head, tail, cursor and the full
// flag update together with at most one write into the entry register file. The
// receiver cannot stall the block, so every result must be taken in the cycle it is shown.
module position_history_ring_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_func,
  input  logic signed [phr_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [phr_pkg::COORD_W-1:0] in_pos_y,
  output logic                     out_valid,
  output logic signed [phr_pkg::COORD_W-1:0] out_cur_x,
  output logic signed [phr_pkg::COORD_W-1:0] out_cur_y,
  output logic                     out_is_empty
);
  import phr_pkg::*;

  idx_t   head_r, head_nxt;
  idx_t   tail_r, tail_nxt;
  idx_t   cursor_r, cursor_nxt;
  logic   full_r, full_nxt;
  logic   busy_r;
  logic   valid_r;
  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  logic   empty_r, empty_nxt;

  logic    accept;
  logic    hist_empty;
  logic    dup;
  idx_t    slot;
  logic    slot_full;
  idx_t    fwd_idx;
  wr_req_t wr;
  coord_t  rd_x, rd_y;

  assign accept     = start && !busy_r;
  assign hist_empty = !full_r && (head_r == tail_r);
  // out regs always mirror the entry at the cursor when the history is not empty
  assign dup        = !hist_empty && (cur_x_r == in_pos_x) && (cur_y_r == in_pos_y);
  // an add truncates everything newer than the cursor
  assign slot       = hist_empty ? head_r : ring_inc(cursor_r);
  assign slot_full  = !hist_empty && (slot == tail_r);
  assign fwd_idx    = ring_inc(cursor_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cursor_nxt = cursor_r;
    full_nxt   = full_r;
    wr.we      = 1'b0;
    wr.addr    = slot;
    wr.x       = in_pos_x;
    wr.y       = in_pos_y;
    if (accept) begin
      case (func_t'(in_func))
        FUNC_ADD: begin
          if (!dup) begin
            wr.we      = 1'b1;
            tail_nxt   = slot_full ? ring_inc(tail_r) : tail_r;
            cursor_nxt = slot;
            head_nxt   = ring_inc(slot);
            full_nxt   = (ring_inc(slot) == tail_nxt);
          end
        end
        FUNC_BACK: begin
          if (!hist_empty && (cursor_r != tail_r)) begin
            cursor_nxt = ring_dec(cursor_r);
          end
        end
        FUNC_FWD: begin
          if (!hist_empty && (fwd_idx != head_r)) begin
            cursor_nxt = fwd_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  phr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (cursor_nxt),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  always_comb begin
    empty_nxt = !full_nxt && (head_nxt == tail_nxt);
    if (empty_nxt) begin
      cur_x_nxt = '0;
      cur_y_nxt = '0;
    end else if (wr.we) begin
      cur_x_nxt = in_pos_x;
      cur_y_nxt = in_pos_y;
    end else begin
      cur_x_nxt = rd_x;
      cur_y_nxt = rd_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      cursor_r <= '0;
      full_r   <= 1'b0;
      busy_r   <= 1'b1;
      valid_r  <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cursor_r <= cursor_nxt;
      full_r   <= full_nxt;
      busy_r   <= 1'b0;
      valid_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      empty_r <= empty_nxt;
    end
  end

  assign busy         = busy_r;
  assign out_valid    = valid_r;
  assign out_cur_x    = cur_x_r;
  assign out_cur_y    = cur_y_r;
  assign out_is_empty = empty_r;

`ifndef NO_ASSERTIONS
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item produced no result strobe");

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (head_r == tail_r))
    else $error("ring full with head and tail apart");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_cur_x == '0 && out_cur_y == '0))
    else $error("empty result with nonzero coordinates");

  a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && func_t'(in_func) == FUNC_ADD) |=> !out_is_empty)
    else $error("history empty after add");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (!full_r && head_r == tail_r)))
    else $error("empty flag disagrees with pointers");
`endif

endmodule
